/* src/triangle_tangent_basis_assert.svh */
// Assertion macros for the checker file of the tangent basis block
`ifndef TRIANGLE_TANGENT_BASIS_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_ASSERT_SVH

// same-cycle implication
`define TTB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// next-cycle implication
`define TTB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

/* src/ttb_pkg.sv */
// Package of widths, types and constants for the tangent basis block
package ttb_pkg;

    localparam int POS_W     = 20;
    localparam int UV_W      = 16;
    localparam int OUT_W     = 16;
    localparam int OUT_FRAC  = OUT_W - 2;
    localparam int NORM_BITS = 30;

    localparam int DP_W   = POS_W + 1;
    localparam int DUV_W  = UV_W + 1;
    localparam int VEC_W  = DP_W + DUV_W + 1;
    localparam int DET_W  = 2 * DUV_W + 1;
    localparam int MAG_W  = VEC_W;
    localparam int MUL_W  = NORM_BITS + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SQ_W   = 2 * NORM_BITS + 2;
    localparam int ROOT_W = NORM_BITS + 1;
    localparam int NUM_W  = NORM_BITS + OUT_FRAC + 1;
    localparam int Q_W    = OUT_FRAC + 2;
    localparam int DIV_W  = ROOT_W + Q_W - 1;
    localparam int J_W    = $clog2(NORM_BITS + 1);

    localparam logic [Q_W-1:0] Q_LIM = Q_W'(1) << OUT_FRAC;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [UV_W-1:0]  t_uv;
    typedef logic signed [DP_W-1:0]  t_dp;
    typedef logic signed [DUV_W-1:0] t_duv;
    typedef logic signed [OUT_W-1:0] t_oc;

    typedef struct packed {
        t_dp [2:0] dp1;
        t_dp [2:0] dp2;
        t_duv      du1;
        t_duv      dv1;
        t_duv      du2;
        t_duv      dv2;
    } t_job;

    typedef struct packed {
        t_oc [2:0] tan;
        t_oc [2:0] btn;
        logic      degenerate;
    } t_res;

    typedef struct packed {
        logic start;
        logic take;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

endpackage

/* src/ttb_ifs.sv */
// Valid/ready channel interfaces for vertex requests and basis results
interface ttb_vtx_if;
    logic          valid;
    logic          ready;
    ttb_pkg::t_pos pos_x;
    ttb_pkg::t_pos pos_y;
    ttb_pkg::t_pos pos_z;
    ttb_pkg::t_uv  tex_u;
    ttb_pkg::t_uv  tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_res_if;
    logic         valid;
    logic         ready;
    ttb_pkg::t_oc tan_x;
    ttb_pkg::t_oc tan_y;
    ttb_pkg::t_oc tan_z;
    ttb_pkg::t_oc bitan_x;
    ttb_pkg::t_oc bitan_y;
    ttb_pkg::t_oc bitan_z;
    logic         degenerate;

    modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    degenerate, input ready);
    modport sink   (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    degenerate, output ready);
endinterface

/* src/ttb_core.sv */
// Sequencer around one shared multiplier, square-root step and divide step
module ttb_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ttb_pkg::t_core_ctl    i_ctl,
    input  ttb_pkg::t_job         i_job,
    output ttb_pkg::t_core_sts    o_sts,
    output ttb_pkg::t_res         o_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SIGN  = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_SHIFT = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [3:0] K_LAST  = 4'd14;
    localparam logic [3:0] K_SQ    = 4'd3;

    logic [3:0]                         r_state;
    logic [3:0]                         r_k;
    logic [ttb_pkg::J_W-1:0]            r_j;
    logic [1:0]                         r_i;
    logic                               r_vsel;
    ttb_pkg::t_job                      r_job;
    logic signed [ttb_pkg::VEC_W-1:0]   r_acc;
    logic signed [ttb_pkg::DET_W-1:0]   r_det;
    logic signed [ttb_pkg::VEC_W-1:0]   r_vec [6];
    logic signed [ttb_pkg::PROD_W-1:0]  r_prod;
    logic [ttb_pkg::MAG_W-1:0]          r_mag [3];
    logic [2:0]                         r_neg;
    logic [ttb_pkg::SQ_W-1:0]           r_sum;
    logic [ttb_pkg::SQ_W-1:0]           r_s;
    logic [ttb_pkg::SQ_W-1:0]           r_r;
    logic [ttb_pkg::ROOT_W-1:0]         r_len;
    logic [ttb_pkg::NUM_W-1:0]          r_rem;
    logic [ttb_pkg::Q_W-1:0]            r_q;
    ttb_pkg::t_oc                       r_tan [3];
    ttb_pkg::t_oc                       r_btn [3];
    logic                               r_degen;

    logic signed [ttb_pkg::MUL_W-1:0]   mul_a;
    logic signed [ttb_pkg::MUL_W-1:0]   mul_b;
    logic [2:0]                         step_p;
    logic [2:0]                         step_i;
    logic [3:0]                         km;
    logic [2:0]                         km_p;
    logic signed [ttb_pkg::VEC_W-1:0]   diff;
    logic [ttb_pkg::MAG_W-1:0]          mag_sel;
    logic                               mag_hi;
    logic                               mag_top;
    logic [ttb_pkg::SQ_W-1:0]           root_bit;
    logic [ttb_pkg::SQ_W-1:0]           root_try;
    logic                               root_ge;
    logic [ttb_pkg::SQ_W-1:0]           n_r;
    logic [ttb_pkg::DIV_W-1:0]          div_d;
    logic [ttb_pkg::DIV_W-1:0]          div_rem;
    logic                               div_ge;
    logic [ttb_pkg::Q_W-1:0]            n_q;
    logic [ttb_pkg::Q_W-1:0]            q_clamp;
    ttb_pkg::t_oc                       q_out;
    logic                               degen;

    // pick the operands of the shared multiplier
    assign step_p = r_k[3:1];
    assign step_i = (step_p >= 3'd4) ? (step_p - 3'd4) : (step_p - 3'd1);

    always_comb begin
        mag_sel = r_mag[0];
        case (r_k[1:0])
            2'd1:    mag_sel = r_mag[1];
            2'd2:    mag_sel = r_mag[2];
            default: mag_sel = r_mag[0];
        endcase
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_SQ) begin
            mul_a = $signed({1'b0, mag_sel[ttb_pkg::NORM_BITS-1:0]});
            mul_b = $signed({1'b0, mag_sel[ttb_pkg::NORM_BITS-1:0]});
        end else begin
            case (step_p)
                3'd0: begin
                    mul_a = ttb_pkg::MUL_W'(r_k[0] ? r_job.du2 : r_job.du1);
                    mul_b = ttb_pkg::MUL_W'(r_k[0] ? r_job.dv1 : r_job.dv2);
                end
                3'd1, 3'd2, 3'd3: begin
                    mul_a = ttb_pkg::MUL_W'(r_k[0] ? r_job.dv1 : r_job.dv2);
                    mul_b = ttb_pkg::MUL_W'(r_k[0] ? $signed(r_job.dp2[step_i[1:0]])
                                                   : $signed(r_job.dp1[step_i[1:0]]));
                end
                3'd4, 3'd5, 3'd6: begin
                    mul_a = ttb_pkg::MUL_W'(r_k[0] ? r_job.du2 : r_job.du1);
                    mul_b = ttb_pkg::MUL_W'(r_k[0] ? $signed(r_job.dp1[step_i[1:0]])
                                                   : $signed(r_job.dp2[step_i[1:0]]));
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // register every product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // cross-product bookkeeping
    assign km   = r_k - 4'd1;
    assign km_p = km[3:1];
    assign diff = r_acc - ttb_pkg::VEC_W'(r_prod);

    // shift window tests
    assign mag_hi  = (|r_mag[0][ttb_pkg::MAG_W-1:ttb_pkg::NORM_BITS])
                   | (|r_mag[1][ttb_pkg::MAG_W-1:ttb_pkg::NORM_BITS])
                   | (|r_mag[2][ttb_pkg::MAG_W-1:ttb_pkg::NORM_BITS]);
    assign mag_top = r_mag[0][ttb_pkg::NORM_BITS-1] | r_mag[1][ttb_pkg::NORM_BITS-1]
                   | r_mag[2][ttb_pkg::NORM_BITS-1];

    // one square-root digit
    assign root_bit = ttb_pkg::SQ_W'(1) << {r_j, 1'b0};
    assign root_try = r_r + root_bit;
    assign root_ge  = (r_s >= root_try);
    assign n_r      = root_ge ? ((r_r >> 1) + root_bit) : (r_r >> 1);

    // one quotient bit
    assign div_d   = ttb_pkg::DIV_W'(r_len) << r_j;
    assign div_rem = ttb_pkg::DIV_W'(r_rem);
    assign div_ge  = (div_rem >= div_d);
    assign n_q     = {r_q[ttb_pkg::Q_W-2:0], div_ge};
    assign q_clamp = (n_q > ttb_pkg::Q_LIM) ? ttb_pkg::Q_LIM : n_q;
    assign q_out   = r_neg[r_i] ? -ttb_pkg::OUT_W'(q_clamp) : ttb_pkg::OUT_W'(q_clamp);

    assign degen = (r_det == '0)
                 || (r_vec[0] == '0 && r_vec[1] == '0 && r_vec[2] == '0)
                 || (r_vec[3] == '0 && r_vec[4] == '0 && r_vec[5] == '0);

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_k == K_LAST) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    r_state <= degen ? S_DONE : S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (!mag_hi && mag_top) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_k == K_SQ) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (r_j == '0) begin
                        r_state <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_j == '0) begin
                        if (r_i == 2'd2) begin
                            r_state <= r_vsel ? S_DONE : S_LOAD;
                        end else begin
                            r_state <= S_DIVI;
                        end
                    end
                end
                S_DONE: begin
                    if (i_ctl.take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_k   <= '0;
            end
            S_MUL: begin
                if (r_k != '0) begin
                    if (!km[0]) begin
                        r_acc <= ttb_pkg::VEC_W'(r_prod);
                    end else if (km_p == 3'd0) begin
                        r_det <= ttb_pkg::DET_W'(diff);
                    end else begin
                        r_vec[km_p - 3'd1] <= diff;
                    end
                end
                r_k <= r_k + 4'd1;
            end
            S_SIGN: begin
                r_vsel <= 1'b0;
                r_degen <= degen;
                if (degen) begin
                    for (int i = 0; i < 3; i++) begin
                        r_tan[i] <= '0;
                        r_btn[i] <= '0;
                    end
                end else if (r_det < 0) begin
                    for (int i = 0; i < 6; i++) begin
                        r_vec[i] <= -r_vec[i];
                    end
                end
            end
            S_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_vsel) begin
                        r_neg[i] <= r_vec[3+i] < 0;
                        r_mag[i] <= (r_vec[3+i] < 0) ? ttb_pkg::MAG_W'(-r_vec[3+i])
                                                     : ttb_pkg::MAG_W'(r_vec[3+i]);
                    end else begin
                        r_neg[i] <= r_vec[i] < 0;
                        r_mag[i] <= (r_vec[i] < 0) ? ttb_pkg::MAG_W'(-r_vec[i])
                                                   : ttb_pkg::MAG_W'(r_vec[i]);
                    end
                end
            end
            S_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    if (mag_hi) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end else if (!mag_top) begin
                        r_mag[i] <= r_mag[i] << 1;
                    end
                end
                r_k   <= '0;
                r_sum <= '0;
            end
            S_SQ: begin
                if (r_k != '0) begin
                    r_sum <= r_sum + ttb_pkg::SQ_W'(r_prod);
                end
                r_s <= r_sum + ttb_pkg::SQ_W'(r_prod);
                r_r <= '0;
                r_j <= ttb_pkg::J_W'(ttb_pkg::NORM_BITS);
                r_k <= r_k + 4'd1;
            end
            S_ROOT: begin
                if (root_ge) begin
                    r_s <= r_s - root_try;
                end
                r_r   <= n_r;
                r_j   <= r_j - 1'b1;
                r_len <= ttb_pkg::ROOT_W'(n_r);
                r_i   <= '0;
            end
            S_DIVI: begin
                r_rem <= (ttb_pkg::NUM_W'(r_mag[r_i][ttb_pkg::NORM_BITS-1:0])
                          << ttb_pkg::OUT_FRAC) + ttb_pkg::NUM_W'(r_len >> 1);
                r_q   <= '0;
                r_j   <= ttb_pkg::J_W'(ttb_pkg::Q_W - 1);
            end
            S_DIV: begin
                if (div_ge) begin
                    r_rem <= ttb_pkg::NUM_W'(div_rem - div_d);
                end
                r_q <= n_q;
                r_j <= r_j - 1'b1;
                if (r_j == '0) begin
                    if (r_vsel) begin
                        r_btn[r_i] <= q_out;
                    end else begin
                        r_tan[r_i] <= q_out;
                    end
                    if (r_i == 2'd2) begin
                        r_vsel <= 1'b1;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // present status and result
    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = (r_state == S_DONE);
    assign o_res.tan  = {r_tan[2], r_tan[1], r_tan[0]};
    assign o_res.btn  = {r_btn[2], r_btn[1], r_btn[0]};
    assign o_res.degenerate = r_degen;

endmodule

/* src/triangle_tangent_basis.sv */
// Top level: corner store, request handshake and result register
//
//   channel  direction  carries
//   i_vtx    in         one vertex: pos_x/y/z, tex_u/v
//   o_res    out        one basis per triangle: tan_x/y/z, bitan_x/y/z, degenerate
//
// The first two corners of a triangle are only stored in the corner store.
// The third corner runs the shared multiplier and a sign step, then per vector a load,
// shift, square, root and divide phase, then a hand-over step to the result register;
// a degenerate triangle goes from the sign step straight to the hand-over.
// Synchronous active-low reset clears the corner count, the sequencer and the result valid.
// i_vtx.ready is low while the core is busy; a finished result is held in the core
// only while the result register still holds one that has not been accepted.
module triangle_tangent_basis (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttb_vtx_if.sink     i_vtx,
    ttb_res_if.source   o_res
);

    localparam logic [1:0] CNT_FIRST  = 2'd0;
    localparam logic [1:0] CNT_SECOND = 2'd1;
    localparam logic [1:0] CNT_THIRD  = 2'd2;

    logic [1:0]          r_cnt;
    ttb_pkg::t_pos       r_p1 [3];
    ttb_pkg::t_pos       r_p2 [3];
    ttb_pkg::t_uv        r_u1;
    ttb_pkg::t_uv        r_v1;
    ttb_pkg::t_uv        r_u2;
    ttb_pkg::t_uv        r_v2;
    logic                r_ov;
    ttb_pkg::t_res       r_out;

    ttb_pkg::t_pos       in_p [3];
    ttb_pkg::t_job       job;
    ttb_pkg::t_core_ctl  ctl;
    ttb_pkg::t_core_sts  sts;
    ttb_pkg::t_res       core_res;
    logic                accept;

    assign in_p[0] = i_vtx.pos_x;
    assign in_p[1] = i_vtx.pos_y;
    assign in_p[2] = i_vtx.pos_z;

    assign i_vtx.ready = !sts.busy;
    assign accept      = i_vtx.valid && i_vtx.ready;

    // form edge and uv deltas against the first corner
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            job.dp1[i] = ttb_pkg::DP_W'(r_p2[i]) - ttb_pkg::DP_W'(r_p1[i]);
            job.dp2[i] = ttb_pkg::DP_W'(in_p[i]) - ttb_pkg::DP_W'(r_p1[i]);
        end
        job.du1 = ttb_pkg::DUV_W'(r_u2) - ttb_pkg::DUV_W'(r_u1);
        job.dv1 = ttb_pkg::DUV_W'(r_v2) - ttb_pkg::DUV_W'(r_v1);
        job.du2 = ttb_pkg::DUV_W'(i_vtx.tex_u) - ttb_pkg::DUV_W'(r_u1);
        job.dv2 = ttb_pkg::DUV_W'(i_vtx.tex_v) - ttb_pkg::DUV_W'(r_v1);
    end

    assign ctl.start = accept && (r_cnt != CNT_FIRST) && (r_cnt != CNT_SECOND);
    assign ctl.take  = sts.done && (!r_ov || o_res.ready);

    ttb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_job   (job),
        .o_sts   (sts),
        .o_res   (core_res)
    );

    // count corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_FIRST;
        end else if (accept) begin
            case (r_cnt)
                CNT_FIRST:  r_cnt <= CNT_SECOND;
                CNT_SECOND: r_cnt <= CNT_THIRD;
                default:    r_cnt <= CNT_FIRST;
            endcase
        end
    end

    // hold the first two corners
    always_ff @(posedge i_clk) begin
        if (accept && r_cnt == CNT_FIRST) begin
            r_p1 <= in_p;
            r_u1 <= i_vtx.tex_u;
            r_v1 <= i_vtx.tex_v;
        end
        if (accept && r_cnt == CNT_SECOND) begin
            r_p2 <= in_p;
            r_u2 <= i_vtx.tex_u;
            r_v2 <= i_vtx.tex_v;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ctl.take) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.take) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.tan_x      = r_out.tan[0];
    assign o_res.tan_y      = r_out.tan[1];
    assign o_res.tan_z      = r_out.tan[2];
    assign o_res.bitan_x    = r_out.btn[0];
    assign o_res.bitan_y    = r_out.btn[1];
    assign o_res.bitan_z    = r_out.btn[2];
    assign o_res.degenerate = r_out.degenerate;

endmodule

/* src/ttb_checker.sv */
// Port-level checker for the tangent basis block and its bind
`include "triangle_tangent_basis_assert.svh"

module ttb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_vtx_valid,
    input logic         i_vtx_ready,
    input logic         i_res_valid,
    input logic         i_res_ready,
    input ttb_pkg::t_oc i_tan_x,
    input ttb_pkg::t_oc i_tan_y,
    input ttb_pkg::t_oc i_tan_z,
    input ttb_pkg::t_oc i_bitan_x,
    input ttb_pkg::t_oc i_bitan_y,
    input ttb_pkg::t_oc i_bitan_z,
    input logic         i_degenerate
);

    localparam logic [1:0] CNT_LAST = 2'd2;

    logic [1:0] r_cnt;
    logic       acc;

    assign acc = i_vtx_valid && i_vtx_ready;

    // track the corner position seen at the ports
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (acc) begin
            r_cnt <= (r_cnt == CNT_LAST) ? 2'd0 : r_cnt + 2'd1;
        end
    end

    `TTB_ASSERT_NXT(a_third_blocks, i_clk, i_rst_n, acc && r_cnt == CNT_LAST, !i_vtx_ready)
    `TTB_ASSERT_NXT(a_corner_free, i_clk, i_rst_n, acc && r_cnt != CNT_LAST, i_vtx_ready)
    `TTB_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable({i_tan_x, i_tan_y, i_tan_z, i_bitan_x, i_bitan_y, i_bitan_z, i_degenerate}))
    `TTB_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, i_res_valid && i_degenerate, i_tan_x == 0 && i_tan_y == 0 && i_tan_z == 0 && i_bitan_x == 0 && i_bitan_y == 0 && i_bitan_z == 0)

endmodule

bind triangle_tangent_basis ttb_checker u_ttb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_vtx_valid  (i_vtx.valid),
    .i_vtx_ready  (i_vtx.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_tan_x      (o_res.tan_x),
    .i_tan_y      (o_res.tan_y),
    .i_tan_z      (o_res.tan_z),
    .i_bitan_x    (o_res.bitan_x),
    .i_bitan_y    (o_res.bitan_y),
    .i_bitan_z    (o_res.bitan_z),
    .i_degenerate (o_res.degenerate)
);

/* verif/tb.sv */
// Self-checking testbench for the per-triangle tangent basis block
module tb;

    typedef ttb_pkg::t_oc [2:0] t_dir;

    typedef struct packed {
        ttb_pkg::t_pos x;
        ttb_pkg::t_pos y;
        ttb_pkg::t_pos z;
        ttb_pkg::t_uv  u;
        ttb_pkg::t_uv  v;
    } t_vertex;

    typedef struct packed {
        logic          typed;
        ttb_pkg::t_res res;
        t_vertex       vtx;
    } t_row;

    localparam longint unsigned UNIT = 64'd1 << ttb_pkg::OUT_FRAC;

    logic i_clk;
    logic i_rst_n;
    int   error_count;

    ttb_vtx_if vtx_ch();
    ttb_res_if res_ch();

    triangle_tangent_basis i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_ch),
        .o_res   (res_ch)
    );

    // Predictor state: corners held for the triangle in progress
    int      corners_held;
    t_vertex corner_a;
    t_vertex corner_b;

    ttb_pkg::t_res basis_q[$];
    t_row          typed_q[$];
    t_row          stim_rows[$];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard limit on run length
    initial begin
        #30000000;
        $display("FAIL");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scale a non-zero vector to unit length with OUT_FRAC fraction bits
    function automatic t_dir unit_dir(input longint cx, input longint cy, input longint cz);
        longint          c[3];
        longint unsigned mag[3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned len;
        longint unsigned q;
        int              n;
        t_dir            d;
        c[0] = cx;
        c[1] = cy;
        c[2] = cz;
        m = 0;
        s = 0;
        n = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
            if (mag[i] > m) m = mag[i];
        end
        while (n < 63 && (m >> n) != 0) n++;
        for (int i = 0; i < 3; i++) begin
            if (n > ttb_pkg::NORM_BITS) mag[i] >>= (n - ttb_pkg::NORM_BITS);
            else mag[i] <<= (ttb_pkg::NORM_BITS - n);
            s += mag[i] * mag[i];
        end
        len = int_sqrt(s);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << ttb_pkg::OUT_FRAC) + (len >> 1)) / len;
            if (q > UNIT) q = UNIT;
            d[i] = (c[i] < 0) ? ttb_pkg::t_oc'(-longint'(q)) : ttb_pkg::t_oc'(q);
        end
        return d;
    endfunction

    // Tangent and bitangent of the triangle closed by vertex c
    function automatic ttb_pkg::t_res tangent_basis(input t_vertex a, input t_vertex b,
                                                    input t_vertex c);
        longint        pa[3], pb[3], pc[3];
        longint        dp1[3], dp2[3], tv[3], bv[3];
        longint        du1, dv1, du2, dv2, det;
        ttb_pkg::t_res r;
        pa = '{longint'(a.x), longint'(a.y), longint'(a.z)};
        pb = '{longint'(b.x), longint'(b.y), longint'(b.z)};
        pc = '{longint'(c.x), longint'(c.y), longint'(c.z)};
        du1 = longint'(b.u) - longint'(a.u);
        dv1 = longint'(b.v) - longint'(a.v);
        du2 = longint'(c.u) - longint'(a.u);
        dv2 = longint'(c.v) - longint'(a.v);
        det = du1 * dv2 - du2 * dv1;
        for (int i = 0; i < 3; i++) begin
            dp1[i] = pb[i] - pa[i];
            dp2[i] = pc[i] - pa[i];
            tv[i] = dv2 * dp1[i] - dv1 * dp2[i];
            bv[i] = du1 * dp2[i] - du2 * dp1[i];
            if (det < 0) begin
                tv[i] = -tv[i];
                bv[i] = -bv[i];
            end
        end
        r = '0;
        if (det == 0 || (tv[0] == 0 && tv[1] == 0 && tv[2] == 0)
                || (bv[0] == 0 && bv[1] == 0 && bv[2] == 0)) begin
            r.degenerate = 1'b1;
        end else begin
            r.tan = unit_dir(tv[0], tv[1], tv[2]);
            r.btn = unit_dir(bv[0], bv[1], bv[2]);
        end
        return r;
    endfunction

    function automatic t_vertex mk_vtx(input int x, input int y, input int z,
                                       input int u, input int v);
        t_vertex w;
        w.x = ttb_pkg::t_pos'(x);
        w.y = ttb_pkg::t_pos'(y);
        w.z = ttb_pkg::t_pos'(z);
        w.u = ttb_pkg::t_uv'(u);
        w.v = ttb_pkg::t_uv'(v);
        return w;
    endfunction

    function automatic ttb_pkg::t_res mk_res(input int tx, input int ty, input int tz,
                                             input int bx, input int by, input int bz,
                                             input logic dg);
        ttb_pkg::t_res r;
        r.tan = '{ttb_pkg::t_oc'(tz), ttb_pkg::t_oc'(ty), ttb_pkg::t_oc'(tx)};
        r.btn = '{ttb_pkg::t_oc'(bz), ttb_pkg::t_oc'(by), ttb_pkg::t_oc'(bx)};
        r.degenerate = dg;
        return r;
    endfunction

    // Add one triangle to the stimulus; typed result only where obvious
    task automatic add_tri(input t_vertex a, input t_vertex b, input t_vertex c,
                           input logic typed, input ttb_pkg::t_res want);
        t_row row;
        row.typed = 1'b0;
        row.res   = '0;
        row.vtx   = a;
        stim_rows.insert(stim_rows.size(), row);
        row.vtx   = b;
        stim_rows.insert(stim_rows.size(), row);
        row.typed = typed;
        row.res   = want;
        row.vtx   = c;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    function automatic int rnd_signed(input int bits);
        return int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
    endfunction

    function automatic int near(input int base, input int span);
        return base + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random triangle, mostly well-formed, with degenerate cases mixed in
    task automatic add_random_tri();
        t_vertex a, b, c;
        int      sel, k, ks;
        sel = $urandom_range(0, 9);
        a = mk_vtx(rnd_signed(ttb_pkg::POS_W), rnd_signed(ttb_pkg::POS_W),
                   rnd_signed(ttb_pkg::POS_W), rnd_signed(ttb_pkg::UV_W),
                   rnd_signed(ttb_pkg::UV_W));
        b = mk_vtx(rnd_signed(ttb_pkg::POS_W), rnd_signed(ttb_pkg::POS_W),
                   rnd_signed(ttb_pkg::POS_W), rnd_signed(ttb_pkg::UV_W),
                   rnd_signed(ttb_pkg::UV_W));
        c = mk_vtx(rnd_signed(ttb_pkg::POS_W), rnd_signed(ttb_pkg::POS_W),
                   rnd_signed(ttb_pkg::POS_W), rnd_signed(ttb_pkg::UV_W),
                   rnd_signed(ttb_pkg::UV_W));
        if (sel >= 4 && sel <= 7) begin
            // Small triangle around a random base point
            k  = 1 << $urandom_range(0, 17);
            ks = 1 << $urandom_range(0, 13);
            a = mk_vtx(rnd_signed(ttb_pkg::POS_W - 1), rnd_signed(ttb_pkg::POS_W - 1),
                       rnd_signed(ttb_pkg::POS_W - 1), rnd_signed(ttb_pkg::UV_W - 1),
                       rnd_signed(ttb_pkg::UV_W - 1));
            b = mk_vtx(near(a.x, k), near(a.y, k), near(a.z, k), near(a.u, ks), near(a.v, ks));
            c = mk_vtx(near(a.x, k), near(a.y, k), near(a.z, k), near(a.u, ks), near(a.v, ks));
        end else if (sel == 8) begin
            // Collinear texture coordinates: zero determinant
            b.u = a.u;
            b.v = a.v;
        end else if (sel == 9) begin
            // Coincident positions: zero vectors
            b.x = a.x; b.y = a.y; b.z = a.z;
            c.x = a.x; c.y = a.y; c.z = a.z;
        end
        add_tri(a, b, c, 1'b0, '0);
    endtask

    // Predict on every accepted vertex request
    always @(posedge i_clk) begin
        t_row          row;
        ttb_pkg::t_res want;
        if (i_rst_n && vtx_ch.valid && vtx_ch.ready) begin
            row = typed_q.pop_front();
            if (corners_held == 0) begin
                corner_a = row.vtx;
                corners_held = 1;
            end else if (corners_held == 1) begin
                corner_b = row.vtx;
                corners_held = 2;
            end else begin
                corners_held = 0;
                want = row.typed ? row.res : tangent_basis(corner_a, corner_b, row.vtx);
                basis_q.insert(basis_q.size(), want);
            end
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        ttb_pkg::t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (basis_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                want = basis_q.pop_front();
                if (res_ch.tan_x !== want.tan[0]) report("tan_x", res_ch.tan_x, want.tan[0]);
                if (res_ch.tan_y !== want.tan[1]) report("tan_y", res_ch.tan_y, want.tan[1]);
                if (res_ch.tan_z !== want.tan[2]) report("tan_z", res_ch.tan_z, want.tan[2]);
                if (res_ch.bitan_x !== want.btn[0])
                    report("bitan_x", res_ch.bitan_x, want.btn[0]);
                if (res_ch.bitan_y !== want.btn[1])
                    report("bitan_y", res_ch.bitan_y, want.btn[1]);
                if (res_ch.bitan_z !== want.btn[2])
                    report("bitan_z", res_ch.bitan_z, want.btn[2]);
                if (res_ch.degenerate !== want.degenerate)
                    report("degenerate", res_ch.degenerate, want.degenerate);
            end
        end
    end

    // Receiver stall pattern: free, random, or mostly stalled phases
    int rx_cycle;
    int rx_mode;
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 250 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: res_ch.ready = 1'b1;
            1: res_ch.ready = $urandom_range(0, 1);
            default: res_ch.ready = ($urandom_range(0, 15) == 0);
        endcase
    end

    // Stimulus
    initial begin
        t_row row;
        int   burst;
        int   wait_cycles;
        error_count = 0;
        corners_held = 0;
        rx_cycle = 0;
        rx_mode = 0;
        vtx_ch.valid = 1'b0;
        vtx_ch.pos_x = '0;
        vtx_ch.pos_y = '0;
        vtx_ch.pos_z = '0;
        vtx_ch.tex_u = '0;
        vtx_ch.tex_v = '0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed triangles
        add_tri(mk_vtx(0, 0, 0, 0, 0), mk_vtx(1024, 0, 0, 4096, 0),
                mk_vtx(0, 1024, 0, 0, 4096), 1'b1,
                mk_res(16384, 0, 0, 0, 16384, 0, 1'b0));
        add_tri(mk_vtx(0, 0, 0, 0, 0), mk_vtx(1024, 0, 0, 0, 4096),
                mk_vtx(0, 1024, 0, 4096, 0), 1'b0, '0);
        add_tri(mk_vtx(5, 6, 7, 100, 100), mk_vtx(9, 1, 3, 100, 100),
                mk_vtx(2, 8, 4, 300, 700), 1'b1, mk_res(0, 0, 0, 0, 0, 0, 1'b1));
        add_tri(mk_vtx(77, 77, 77, 0, 0), mk_vtx(77, 77, 77, 4096, 0),
                mk_vtx(77, 77, 77, 0, 4096), 1'b1, mk_res(0, 0, 0, 0, 0, 0, 1'b1));
        add_tri(mk_vtx(-524288, -524288, -524288, -32768, -32768),
                mk_vtx(524287, -524288, 524287, 32767, -32768),
                mk_vtx(-524288, 524287, 524287, -32768, 32767), 1'b0, '0);
        add_tri(mk_vtx(524287, 524287, 524287, 32767, 32767),
                mk_vtx(-524288, 524287, -524288, -32768, 32767),
                mk_vtx(524287, -524288, -524288, 32767, -32768), 1'b0, '0);
        add_tri(mk_vtx(0, 0, 0, 0, 0), mk_vtx(1, 0, 0, 1, 0),
                mk_vtx(0, 0, 1, 0, 1), 1'b0, '0);
        add_tri(mk_vtx(-1, -1, -1, -1, -1), mk_vtx(-1, -1, 0, -1, 0),
                mk_vtx(0, -1, -1, 0, -1), 1'b0, '0);
        repeat (533) add_random_tri();

        // Drive requests in bursts with random gaps
        burst = 0;
        while (stim_rows.size() > 0) begin
            row = stim_rows.pop_front();
            typed_q.insert(typed_q.size(), row);
            vtx_ch.valid = 1'b1;
            vtx_ch.pos_x = row.vtx.x;
            vtx_ch.pos_y = row.vtx.y;
            vtx_ch.pos_z = row.vtx.z;
            vtx_ch.tex_u = row.vtx.u;
            vtx_ch.tex_v = row.vtx.v;
            do @(posedge i_clk); while (!vtx_ch.ready);
            @(negedge i_clk);
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                if (wait_cycles > 0) begin
                    vtx_ch.valid = 1'b0;
                    repeat (wait_cycles - 1) @(negedge i_clk);
                end
            end else begin
                burst--;
            end
        end
        vtx_ch.valid = 1'b0;

        // Drain, then allow for stray results
        wait_cycles = 0;
        while (basis_q.size() > 0 && wait_cycles < 100000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        if (basis_q.size() > 0) report("results left over", basis_q.size(), 0);
        repeat (400) @(negedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/ttb_pkg.sv
src/ttb_ifs.sv
src/ttb_core.sv
src/triangle_tangent_basis.sv
src/ttb_checker.sv
verif/tb.sv
